FILE: rtl/gfgp_pkg.sv
// ----------------------------------------------------------------------------
// gfgp_pkg
// Shared types, widths and rounding helpers for the gravity frame projection.
// ----------------------------------------------------------------------------
package gfgp_pkg;

    localparam int FRAC        = 14;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 19;
    localparam int THR_W       = 15;
    localparam int FV_W        = 18;
    localparam int MAG_W       = 17;
    localparam int SQ_W        = 34;
    localparam int LEN_W       = 17;
    localparam int Q_W         = 15;
    localparam int SQRT_STAGES = 17;
    localparam int DIV_STAGES  = 15;
    localparam int LATENCY     = 3 + SQRT_STAGES + 1 + DIV_STAGES + 5;
    localparam logic [THR_W-1:0] THR_RESET = 15'd16;
    localparam int ACC_W       = 50;

    typedef struct packed {
        logic signed [IN_W-1:0] gx;
        logic signed [IN_W-1:0] gy;
        logic signed [IN_W-1:0] gz;
        logic signed [IN_W-1:0] wx;
        logic signed [IN_W-1:0] wy;
        logic signed [IN_W-1:0] wz;
    } sample_t;

    typedef struct packed {
        sample_t                      s;
        logic [2:0]                   neg;
        logic [2:0][MAG_W-1:0]        mag;
        logic                         fb;
    } side_t;

    function automatic logic signed [FV_W-1:0] round_frac(input logic signed [31:0] v);
        logic [31:0] m;
        logic [31:0] r;
        m = v[31] ? 32'(-v) : 32'(v);
        r = (m + (32'd1 << (FRAC - 1))) >> FRAC;
        return v[31] ? -$signed(FV_W'(r)) : $signed(FV_W'(r));
    endfunction

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] v,
                                                          input int s);
        logic [ACC_W-1:0]        m;
        logic [ACC_W-1:0]        r;
        logic signed [ACC_W:0]   val;
        m   = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r   = (m + (ACC_W'(1) << (s - 1))) >> s;
        val = v[ACC_W-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        if (val > $signed((ACC_W+1)'(262143)))
            return 19'sh3FFFF;
        else if (val < -$signed((ACC_W+1)'(262144)))
            return 19'sh40000;
        else
            return OUT_W'(val);
    endfunction

endpackage

FILE: rtl/gravity_frame_gyro_projection.sv
// ----------------------------------------------------------------------------
// gravity_frame_gyro_projection
// Projects a gyro sample onto a gravity-aligned pointer frame, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  item in   start, busy, grav_*, gyro_*             in (busy out)
//  result    done, mouse_x, mouse_y, fallback_used   out
//  config    cfg_we, cfg_data                        in
//
//  One item per cycle; each result passes through the 17 square-root stages
//  and the 15 divider stages in series.
//  busy stays low: the pipe never stops. Reset clears all valid bits and
//  loads the threshold with 16. Results show for one cycle on done.
// ----------------------------------------------------------------------------
module gravity_frame_gyro_projection (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  grav_x,
    input  logic signed [15:0]  grav_y,
    input  logic signed [15:0]  grav_z,
    input  logic signed [15:0]  gyro_x,
    input  logic signed [15:0]  gyro_y,
    input  logic signed [15:0]  gyro_z,
    input  logic                cfg_we,
    input  logic [14:0]         cfg_data,
    output logic                done,
    output logic signed [18:0]  mouse_x,
    output logic signed [18:0]  mouse_y,
    output logic                fallback_used
);

    localparam int NS = gfgp_pkg::SQRT_STAGES;
    localparam int ND = gfgp_pkg::DIV_STAGES;

    logic [gfgp_pkg::THR_W-1:0] thr_reg;

    // front stages
    logic                       v1_reg, v2_reg;
    gfgp_pkg::sample_t          s1_reg, s2_reg;
    logic signed [31:0]         pxx_reg, pxy_reg, pzz_reg;
    logic signed [gfgp_pkg::FV_W-1:0] f2_reg [3];
    logic [32:0]                sqp_reg [3];
    logic signed [gfgp_pkg::FV_W-1:0] fx_next, fy_next, fz_next;

    // square root stages
    logic                       sv_reg [0:NS];
    gfgp_pkg::side_t            ss_reg [0:NS];
    logic [gfgp_pkg::SQ_W-1:0]  sx_reg [0:NS];
    logic [gfgp_pkg::SQ_W-1:0]  sr_reg [0:NS];

    // divider stages
    logic                       dv_reg [0:ND];
    gfgp_pkg::side_t            ds_reg [0:ND];
    logic [gfgp_pkg::LEN_W-1:0] dl_reg [0:ND];
    logic [16:0]                drem_reg [0:ND][3];
    logic [gfgp_pkg::Q_W-1:0]   dlow_reg [0:ND][3];
    logic [gfgp_pkg::Q_W-1:0]   dq_reg [0:ND][3];

    // back stages
    logic                       v5_reg, v6_reg, v7_reg, v8_reg;
    gfgp_pkg::sample_t          s5_reg;
    logic                       fb5_reg, fb6_reg, fb7_reg, fb8_reg;
    logic signed [15:0]         fu_reg [3];
    logic signed [31:0]         r_reg [3];
    logic signed [33:0]         dg_reg;
    logic signed [15:0]         w6_reg [3];
    logic signed [47:0]         pr_reg [3];
    logic signed [18:0]         mx7_reg, mx8_reg;
    logic signed [gfgp_pkg::ACC_W-1:0] ndr_reg;

    logic                       done_reg, fb_out_reg;
    logic signed [18:0]         mx_out_reg, my_out_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= gfgp_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            sv_reg[0] <= 1'b0;
            dv_reg[0] <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            sv_reg[0] <= v2_reg;
            dv_reg[0] <= sv_reg[NS];
            v5_reg   <= dv_reg[ND];
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            done_reg <= v8_reg;
        end
    end

    always_comb
    begin
        fx_next = gfgp_pkg::round_frac(pxx_reg);
        fy_next = gfgp_pkg::round_frac(pxy_reg);
        fz_next = gfgp_pkg::round_frac(pzz_reg) - gfgp_pkg::FV_W'(1 << gfgp_pkg::FRAC);
    end

    // products, rounding and squares, sum of squares
    always_ff @(posedge clk)
    begin
        s1_reg  <= '{gx: grav_x, gy: grav_y, gz: grav_z,
                     wx: gyro_x, wy: gyro_y, wz: gyro_z};
        pxx_reg <= grav_z * grav_x;
        pxy_reg <= grav_z * grav_y;
        pzz_reg <= grav_z * grav_z;

        s2_reg     <= s1_reg;
        f2_reg[0]  <= fx_next;
        f2_reg[1]  <= fy_next;
        f2_reg[2]  <= fz_next;
        sqp_reg[0] <= 33'(fx_next * fx_next);
        sqp_reg[1] <= 33'(fy_next * fy_next);
        sqp_reg[2] <= 33'(fz_next * fz_next);

        ss_reg[0].s  <= s2_reg;
        ss_reg[0].fb <= 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ss_reg[0].neg[i] <= f2_reg[i][gfgp_pkg::FV_W-1];
            ss_reg[0].mag[i] <= f2_reg[i][gfgp_pkg::FV_W-1]
                                ? gfgp_pkg::MAG_W'(-f2_reg[i])
                                : gfgp_pkg::MAG_W'(f2_reg[i]);
        end
        sx_reg[0] <= gfgp_pkg::SQ_W'(sqp_reg[0]) + gfgp_pkg::SQ_W'(sqp_reg[1])
                     + gfgp_pkg::SQ_W'(sqp_reg[2]);
        sr_reg[0] <= '0;
    end

    // square root: one result bit per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        localparam logic [gfgp_pkg::SQ_W-1:0] BIT = gfgp_pkg::SQ_W'(1) << (32 - 2 * k);
        logic [gfgp_pkg::SQ_W-1:0] t, xn, rn;

        always_comb
        begin
            t = sr_reg[k] + BIT;
            if (sx_reg[k] >= t)
            begin
                xn = sx_reg[k] - t;
                rn = (sr_reg[k] >> 1) + BIT;
            end
            else
            begin
                xn = sx_reg[k];
                rn = sr_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k+1] <= 1'b0;
            else
                sv_reg[k+1] <= sv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            ss_reg[k+1] <= ss_reg[k];
            sx_reg[k+1] <= xn;
            sr_reg[k+1] <= rn;
        end
    end

    // divider setup: numerator = mag << FRAC plus half the length
    always_ff @(posedge clk)
    begin
        logic [gfgp_pkg::LEN_W-1:0] len;
        logic [30:0]                num;
        len = sr_reg[NS][gfgp_pkg::LEN_W-1:0];
        ds_reg[0].s   <= ss_reg[NS].s;
        ds_reg[0].neg <= ss_reg[NS].neg;
        ds_reg[0].mag <= ss_reg[NS].mag;
        ds_reg[0].fb  <= (len <= gfgp_pkg::LEN_W'(thr_reg));
        dl_reg[0]     <= len;
        for (int i = 0; i < 3; i++)
        begin
            num = (31'(ss_reg[NS].mag[i]) << gfgp_pkg::FRAC) + 31'(len >> 1);
            drem_reg[0][i] <= 17'(num[30:15]);
            dlow_reg[0][i] <= num[14:0];
            dq_reg[0][i]   <= '0;
        end
    end

    for (genvar j = 0; j < ND; j++)
    begin : g_div
        for (genvar c = 0; c < 3; c++)
        begin : g_lane
            logic [17:0] t;
            always_comb
                t = {drem_reg[j][c], dlow_reg[j][c][ND-1-j]};

            always_ff @(posedge clk)
            begin
                dlow_reg[j+1][c] <= dlow_reg[j][c];
                if (t >= {1'b0, dl_reg[j]})
                begin
                    drem_reg[j+1][c] <= 17'(t - {1'b0, dl_reg[j]});
                    dq_reg[j+1][c]   <= {dq_reg[j][c][gfgp_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[j+1][c] <= t[16:0];
                    dq_reg[j+1][c]   <= {dq_reg[j][c][gfgp_pkg::Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j+1] <= 1'b0;
            else
                dv_reg[j+1] <= dv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            ds_reg[j+1] <= ds_reg[j];
            dl_reg[j+1] <= dl_reg[j];
        end
    end

    // unit vector select, cross product, dot products, round and clamp
    always_ff @(posedge clk)
    begin
        s5_reg  <= ds_reg[ND].s;
        fb5_reg <= ds_reg[ND].fb;
        for (int i = 0; i < 3; i++)
        begin
            if (ds_reg[ND].fb)
                fu_reg[i] <= (i == 1) ? 16'sd16384 : 16'sd0;
            else if (ds_reg[ND].neg[i])
                fu_reg[i] <= -$signed({1'b0, dq_reg[ND][i]});
            else
                fu_reg[i] <= $signed({1'b0, dq_reg[ND][i]});
        end

        fb6_reg  <= fb5_reg;
        r_reg[0] <= s5_reg.gy * fu_reg[2] - s5_reg.gz * fu_reg[1];
        r_reg[1] <= s5_reg.gz * fu_reg[0] - s5_reg.gx * fu_reg[2];
        r_reg[2] <= s5_reg.gx * fu_reg[1] - s5_reg.gy * fu_reg[0];
        dg_reg   <= 34'(s5_reg.wx * s5_reg.gx) + 34'(s5_reg.wy * s5_reg.gy)
                    + 34'(s5_reg.wz * s5_reg.gz);
        w6_reg[0] <= s5_reg.wx;
        w6_reg[1] <= s5_reg.wy;
        w6_reg[2] <= s5_reg.wz;

        fb7_reg <= fb6_reg;
        for (int i = 0; i < 3; i++)
            pr_reg[i] <= 48'(w6_reg[i] * r_reg[i]);
        mx7_reg <= gfgp_pkg::round_sat(gfgp_pkg::ACC_W'(dg_reg), gfgp_pkg::FRAC);

        fb8_reg <= fb7_reg;
        mx8_reg <= mx7_reg;
        ndr_reg <= -(gfgp_pkg::ACC_W'(pr_reg[0]) + gfgp_pkg::ACC_W'(pr_reg[1])
                     + gfgp_pkg::ACC_W'(pr_reg[2]));

        fb_out_reg <= fb8_reg;
        mx_out_reg <= mx8_reg;
        my_out_reg <= gfgp_pkg::round_sat(ndr_reg, 2 * gfgp_pkg::FRAC);
    end

    assign done          = done_reg;
    assign mouse_x       = mx_out_reg;
    assign mouse_y       = my_out_reg;
    assign fallback_used = fb_out_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##41 done)
        else $error("item did not complete at pipeline depth");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, gfgp_pkg::LATENCY))
        else $error("result without a matching item");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("pipe refused an item");

endmodule
